// ===== src/cobp_pkg.sv =====
package cobp_pkg;

	localparam int MAX_OBJECTS_DEF = 32;
	localparam int BLOCK_WORDS     = 6;
	localparam int WORD_W          = 16;
	localparam int OBJ_W           = BLOCK_WORDS * WORD_W;

	localparam logic [15:0] SYNC_WORD      = 16'haa55;
	localparam logic [15:0] ZERO_WORD      = 16'h0000;
	localparam logic [7:0]  MISS_LIMIT_RST = 8'd16;
	localparam logic [7:0]  EMPTY_THR_RST  = 8'd5;

	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_MISS_LIMIT = 1'b0;
	localparam logic REG_EMPTY_THR  = 1'b1;

	typedef enum logic [1:0] {
		KIND_DONE    = 2'd0,
		KIND_TIMEOUT = 2'd1,
		KIND_FOUND   = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] miss_limit;
		logic [7:0] empty_threshold;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] frame_size;
		logic       frame_empty;
		logic       overflow;
	} result_t;

endpackage

// ===== src/cobp_regs.sv =====
module cobp_regs
	import cobp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.miss_limit      <= MISS_LIMIT_RST;
			cfg_q.empty_threshold <= EMPTY_THR_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_MISS_LIMIT: cfg_q.miss_limit      <= pwdata[7:0];
				REG_EMPTY_THR:  cfg_q.empty_threshold <= pwdata[7:0];
				default:        cfg_q.miss_limit      <= cfg_q.miss_limit;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MISS_LIMIT: prdata = {24'd0, cfg_q.miss_limit};
			REG_EMPTY_THR:  prdata = {24'd0, cfg_q.empty_threshold};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ===== src/cobp_table.sv =====
module cobp_table
	import cobp_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
	parameter int AW          = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [OBJ_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [OBJ_W-1:0] rd_data
);

	logic [OBJ_W-1:0] mem [MAX_OBJECTS];
	logic [OBJ_W-1:0] rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

// ===== src/cobp_ctrl.sv =====
module cobp_ctrl
	import cobp_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
	parameter int AW          = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             cmd,
	input  logic [15:0]      data_word,
	input  logic [5:0]       object_index,
	input  cfg_t             cfg,
	output logic             res_vld,
	output result_t          res,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [OBJ_W-1:0] wr_data,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr
);

	localparam int CW = $clog2(MAX_OBJECTS + 1);

	logic          saving_q, saving_n;
	logic          first_q, first_n;
	logic          lws_q, lws_n;
	logic [7:0]    miss_q, miss_n;
	logic [3:0]    blen_q, blen_n;
	logic [CW-1:0] count_q, count_n;
	logic [7:0]    empty_q, empty_n;
	logic          ovf_q, ovf_n;
	logic [15:0]   words_q [BLOCK_WORDS];

	logic          word_en;
	logic          do_commit;
	logic          good;
	logic          full;
	logic [15:0]   sum;
	logic [7:0]    lim;
	logic [7:0]    miss_inc;
	logic          commit_wr;
	logic          vld;
	kind_t         kind;

	assign sum  = words_q[1] + words_q[2] + words_q[3] + words_q[4] + words_q[5];
	assign good = !first_q && (blen_q >= 4'(BLOCK_WORDS)) && (sum == words_q[0]);
	assign full = !(count_q < CW'(MAX_OBJECTS));
	assign lim  = (cfg.miss_limit == 8'd0) ? 8'd1 : cfg.miss_limit;
	assign miss_inc = (miss_q == 8'hff) ? miss_q : miss_q + 8'd1;

	always_comb begin
		saving_n  = saving_q;
		first_n   = first_q;
		lws_n     = lws_q;
		miss_n    = miss_q;
		blen_n    = blen_q;
		count_n   = count_q;
		empty_n   = empty_q;
		ovf_n     = ovf_q;
		word_en   = 1'b0;
		do_commit = 1'b0;
		commit_wr = 1'b0;
		vld       = 1'b0;
		kind      = KIND_DONE;
		if (cmd == CMD_QUERY) begin
			vld  = 1'b1;
			kind = (7'(object_index) < 7'(count_q)) ? KIND_FOUND : KIND_NONE;
		end else if (!saving_q) begin
			if (data_word == SYNC_WORD) begin
				count_n  = '0;
				ovf_n    = 1'b0;
				saving_n = 1'b1;
				first_n  = 1'b1;
				lws_n    = 1'b0;
				blen_n   = 4'd0;
			end else begin
				miss_n = miss_inc;
				if (miss_inc >= lim) begin
					empty_n  = (empty_q == 8'hff) ? empty_q : empty_q + 8'd1;
					saving_n = 1'b0;
					lws_n    = 1'b0;
					miss_n   = 8'd0;
					blen_n   = 4'd0;
					vld      = 1'b1;
					kind     = KIND_TIMEOUT;
				end
			end
		end else if (data_word == ZERO_WORD) begin
			do_commit = 1'b1;
			first_n   = 1'b0;
			empty_n   = 8'd0;
			saving_n  = 1'b0;
			lws_n     = 1'b0;
			miss_n    = 8'd0;
			blen_n    = 4'd0;
			vld       = 1'b1;
			kind      = KIND_DONE;
		end else if (data_word == SYNC_WORD) begin
			if (!lws_q) begin
				lws_n = 1'b1;
				if (first_q) begin
					first_n = 1'b0;
				end else begin
					do_commit = 1'b1;
				end
			end else begin
				count_n = '0;
				ovf_n   = 1'b0;
			end
			blen_n = 4'd0;
		end else begin
			lws_n   = 1'b0;
			word_en = blen_q < 4'(BLOCK_WORDS);
			blen_n  = (blen_q == 4'hf) ? blen_q : blen_q + 4'd1;
		end
		if (do_commit && good) begin
			if (!full) begin
				commit_wr = 1'b1;
				count_n   = count_q + CW'(1);
			end else begin
				ovf_n = 1'b1;
			end
		end
	end

	assign res_vld         = fire && vld;
	assign res.kind        = kind;
	assign res.frame_size  = 6'(count_n);
	assign res.frame_empty = empty_n >= cfg.empty_threshold;
	assign res.overflow    = ovf_n;

	assign wr_en   = fire && commit_wr;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = {words_q[5], words_q[4], words_q[3], words_q[2], words_q[1], words_q[0]};
	assign rd_en   = fire && (cmd == CMD_QUERY);
	assign rd_addr = object_index[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saving_q <= 1'b0;
			first_q  <= 1'b0;
			lws_q    <= 1'b0;
			miss_q   <= 8'd0;
			blen_q   <= 4'd0;
			count_q  <= '0;
			empty_q  <= 8'd0;
			ovf_q    <= 1'b0;
		end else if (fire) begin
			saving_q <= saving_n;
			first_q  <= first_n;
			lws_q    <= lws_n;
			miss_q   <= miss_n;
			blen_q   <= blen_n;
			count_q  <= count_n;
			empty_q  <= empty_n;
			ovf_q    <= ovf_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && word_en) begin
			words_q[blen_q[2:0]] <= data_word;
		end
	end

endmodule

// ===== src/cobp_out.sv =====
module cobp_out
	import cobp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_vld,
	input  result_t          res,
	input  logic [OBJ_W-1:0] rd_data,
	output logic             in_ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [103:0]     m_tdata,
	output logic [1:0]       m_tuser
);

	logic         valid_s1;
	result_t      res_s1;
	logic         out_vld_q;
	logic [103:0] tdata_q;
	logic [1:0]   tuser_q;
	logic         move;

	assign move     = valid_s1 && (!out_vld_q || m_tready);
	assign in_ready = !valid_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= res_vld;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && res_vld) begin
			res_s1 <= res;
		end
		if (move) begin
			tuser_q <= res_s1.kind;
			tdata_q <= {(res_s1.kind == KIND_FOUND) ? rd_data : {OBJ_W{1'b0}},
				res_s1.overflow, res_s1.frame_empty, res_s1.frame_size};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

endmodule

// ===== src/camera_object_block_parser.sv =====
// A result moves through the s1 register, then the output register driving m_tvalid, behind any waiting result.
// Throughput: one input item per cycle while s_tready is high; a query reads the object memory in its accept cycle.
// One result may wait on the master side while the next input item is taken.
// Reset: arst_n clears the parser state, counters and valid flags at once; the registers
// return to miss limit 16 and empty threshold 5. The object memory is not cleared.
module camera_object_block_parser
	import cobp_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,  // data_word[15:0], object_index[21:16], zero[23:22]
	input  logic         s_tuser,  // cmd[0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,  // frame_size[5:0], frame_empty[6], table_overflow[7],
	                               // obj_checksum[23:8], obj_signature[39:24], obj_x[55:40],
	                               // obj_y[71:56], obj_width[87:72], obj_height[103:88]
	output logic [1:0]   m_tuser,  // kind[1:0]
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

	cfg_t             cfg;
	logic             fire;
	logic             res_vld;
	result_t          res;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [OBJ_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [OBJ_W-1:0] rd_data;

	assign fire = s_tvalid && s_tready;

	cobp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cobp_ctrl #(
		.MAX_OBJECTS (MAX_OBJECTS),
		.AW          (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.cmd          (s_tuser),
		.data_word    (s_tdata[15:0]),
		.object_index (s_tdata[21:16]),
		.cfg          (cfg),
		.res_vld      (res_vld),
		.res          (res),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr)
	);

	cobp_table #(
		.MAX_OBJECTS (MAX_OBJECTS),
		.AW          (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cobp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_vld  (res_vld),
		.res      (res),
		.rd_data  (rd_data),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== src/cobp_checker.sv =====
module cobp_checker
	import cobp_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic [1:0]   m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	a_zero_obj: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_FOUND) |-> m_tdata[103:8] == '0)
		else $error("object fields set on a result without an object");

	a_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_FOUND) |->
		16'(m_tdata[39:24] + m_tdata[55:40] + m_tdata[71:56] + m_tdata[87:72]
			+ m_tdata[103:88]) == m_tdata[23:8])
		else $error("returned object fails its checksum");

	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 7'(m_tdata[5:0]) <= 7'(MAX_OBJECTS))
		else $error("frame size beyond table depth");

endmodule

bind camera_object_block_parser cobp_checker #(
	.MAX_OBJECTS (MAX_OBJECTS)
) u_cobp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/camera_object_block_parser_tb.sv =====
`timescale 1ns / 1ps

module camera_object_block_parser_tb;
	import cobp_pkg::*;

	typedef struct packed {
		logic        cmd;
		logic [5:0]  index;
		logic [15:0] word;
		logic        hold;
	} cam_item_t;

	typedef struct packed {
		kind_t           kind;
		logic [5:0]      frame_size;
		logic            frame_empty;
		logic            overflow;
		logic [5:0][15:0] words;
	} parse_report_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [23:0]  s_tdata = '0;  // data_word[15:0], object_index[21:16], zero[23:22]
	logic         s_tuser = 1'b0;  // cmd[0]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;  // frame_size[5:0], frame_empty[6], table_overflow[7],
	                        // obj_checksum[23:8] .. obj_height[103:88]
	logic [1:0]   m_tuser;  // kind[1:0]
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	camera_object_block_parser #(
		.MAX_OBJECTS(MAX_OBJECTS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// parser model state
	int              miss_lim = int'(MISS_LIMIT_RST);
	int              empty_thr = int'(EMPTY_THR_RST);
	bit              p_saving = 1'b0;
	bit              p_first = 1'b0;
	bit              p_last_sync = 1'b0;
	int              miss_cnt = 0;
	logic [5:0][15:0] blk = '0;
	int              blk_len = 0;
	logic [5:0][15:0] obj_tab [MAX_OBJECTS_DEF];
	int              obj_count = 0;
	int              empty_cnt = 0;
	bit              ovf = 1'b0;

	cam_item_t       pending_items[$];
	parse_report_t   reports_due[$];
	int              pushed_cnt = 0;
	int              accepted_cnt = 0;
	int              err_cnt = 0;

	task automatic end_collection();
		p_saving = 1'b0;
		p_last_sync = 1'b0;
		miss_cnt = 0;
		blk_len = 0;
	endtask

	task automatic store_block();
		logic [15:0] sum;
		sum = blk[1] + blk[2] + blk[3] + blk[4] + blk[5];
		if (p_first || blk_len < BLOCK_WORDS || sum != blk[0])
			return;
		if (obj_count < MAX_OBJECTS_DEF) begin
			obj_tab[obj_count] = blk;
			obj_count++;
		end else begin
			ovf = 1'b1;
		end
	endtask

	task automatic parse_item(input cam_item_t it, output bit got, output parse_report_t r);
		int lim;
		r = '0;
		got = 1'b0;
		if (it.cmd == CMD_QUERY) begin
			got = 1'b1;
			if (it.index < obj_count) begin
				r.kind = KIND_FOUND;
				r.words = obj_tab[it.index];
			end else begin
				r.kind = KIND_NONE;
			end
		end else if (!p_saving) begin
			if (it.word == SYNC_WORD) begin
				obj_count = 0;
				ovf = 1'b0;
				p_saving = 1'b1;
				p_first = 1'b1;
				p_last_sync = 1'b0;
				blk_len = 0;
			end else begin
				if (miss_cnt < 255)
					miss_cnt++;
				lim = (miss_lim == 0) ? 1 : miss_lim;
				if (miss_cnt >= lim) begin
					if (empty_cnt < 255)
						empty_cnt++;
					end_collection();
					r.kind = KIND_TIMEOUT;
					got = 1'b1;
				end
			end
		end else if (it.word == ZERO_WORD) begin
			store_block();
			p_first = 1'b0;
			empty_cnt = 0;
			end_collection();
			r.kind = KIND_DONE;
			got = 1'b1;
		end else if (it.word == SYNC_WORD) begin
			if (!p_last_sync) begin
				p_last_sync = 1'b1;
				if (p_first)
					p_first = 1'b0;
				else
					store_block();
			end else begin
				obj_count = 0;
				ovf = 1'b0;
			end
			blk_len = 0;
		end else begin
			p_last_sync = 1'b0;
			if (blk_len < BLOCK_WORDS)
				blk[blk_len] = it.word;
			if (blk_len < 15)
				blk_len++;
		end
		if (got) begin
			r.frame_size = obj_count[5:0];
			r.frame_empty = (empty_cnt >= empty_thr);
			r.overflow = ovf;
		end
	endtask

	// sender: bursts with gaps, optional hold until all results are back
	int        tx_burst_left = 0;
	int        tx_gap_left = 0;
	cam_item_t tx_cur = '0;
	cam_item_t tx_nxt;
	bit        tx_offer;
	bit        tx_got;
	parse_report_t tx_rep;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid) begin
				parse_item(tx_cur, tx_got, tx_rep);
				if (tx_got)
					reports_due.insert(reports_due.size(), tx_rep);
				accepted_cnt++;
			end
			tx_offer = 1'b0;
			if (tx_gap_left > 0) begin
				tx_gap_left--;
			end else if (pending_items.size() > 0 &&
					!(pending_items[0].hold && reports_due.size() != 0)) begin
				tx_offer = 1'b1;
				tx_nxt = pending_items.pop_front();
				if (tx_burst_left == 0)
					tx_burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 16);
				tx_burst_left--;
				if (tx_burst_left == 0)
					tx_gap_left = $urandom_range(1, 6);
			end
			s_tvalid <= tx_offer;
			if (tx_offer) begin
				tx_cur = tx_nxt;
				s_tdata <= {2'b00, tx_nxt.index, tx_nxt.word};
				s_tuser <= tx_nxt.cmd;
			end
		end
	end

	// receiver: stall pattern switches mode every so often
	int            rx_mode = 0;
	int            rx_left = 0;
	int            rx_cnt = 0;
	bit            rx_rdy;
	parse_report_t rx_rep;
	string         word_names[BLOCK_WORDS] = '{"obj_checksum", "obj_signature", "obj_x",
		"obj_y", "obj_width", "obj_height"};

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					$display("%0t: unexpected result item: expected none, actual kind %0d tdata %h",
						$time, m_tuser, m_tdata);
					err_cnt++;
				end else begin
					rx_rep = reports_due.pop_front();
					check_field("kind", 16'(rx_rep.kind), 16'(m_tuser));
					check_field("frame_size", 16'(rx_rep.frame_size), 16'(m_tdata[5:0]));
					check_field("frame_empty", 16'(rx_rep.frame_empty), 16'(m_tdata[6]));
					check_field("table_overflow", 16'(rx_rep.overflow), 16'(m_tdata[7]));
					for (int j = 0; j < BLOCK_WORDS; j++)
						check_field(word_names[j], rx_rep.words[j], m_tdata[8 + 16 * j +: 16]);
				end
			end
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(50, 300);
			end
			rx_left--;
			rx_cnt++;
			case (rx_mode)
				0: rx_rdy = 1'b1;
				1: rx_rdy = 1'($urandom_range(0, 1));
				2: rx_rdy = (rx_cnt % 4 == 0);
				default: rx_rdy = ($urandom_range(0, 7) == 0);
			endcase
			m_tready <= rx_rdy;
		end
	end

	task automatic push(input logic cmd, input logic [15:0] word, input logic [5:0] idx,
			input bit hold = 1'b0);
		cam_item_t it;
		it.cmd = cmd;
		it.word = word;
		it.index = idx;
		it.hold = hold;
		pending_items.insert(pending_items.size(), it);
		pushed_cnt++;
	endtask

	function automatic logic [15:0] nz_word();
		logic [15:0] w;
		case ($urandom_range(0, 15))
			0: return 16'hffff;
			1: return 16'h0001;
			default: begin
				do w = 16'($urandom); while (w == ZERO_WORD || w == SYNC_WORD);
				return w;
			end
		endcase
	endfunction

	task automatic push_block();
		logic [5:0][15:0] w;
		int mode;
		int n;
		mode = $urandom_range(0, 9);
		for (int j = 1; j < BLOCK_WORDS; j++)
			w[j] = nz_word();
		w[0] = w[1] + w[2] + w[3] + w[4] + w[5];
		if (mode == 7)
			w[0] = nz_word();
		push(CMD_DATA, SYNC_WORD, 6'($urandom));
		n = (mode == 8) ? $urandom_range(0, 5) : BLOCK_WORDS;
		for (int j = 0; j < n; j++)
			push(CMD_DATA, w[j], 6'($urandom));
		if (mode == 6)
			for (int j = $urandom_range(1, 3); j > 0; j--)
				push(CMD_DATA, nz_word(), 6'($urandom));
	endtask

	task automatic gen_frame(input int nblk);
		for (int j = $urandom_range(0, 2); j > 0; j--)
			push(CMD_DATA, ($urandom_range(0, 3) == 0) ? ZERO_WORD : nz_word(), 6'($urandom));
		push(CMD_DATA, SYNC_WORD, 6'($urandom), $urandom_range(0, 9) == 0);
		if ($urandom_range(0, 3) == 0)
			for (int j = $urandom_range(1, 3); j > 0; j--)
				push(CMD_DATA, nz_word(), 6'($urandom));
		for (int j = 0; j < nblk; j++) begin
			if ($urandom_range(0, 12) == 0)
				push(CMD_DATA, SYNC_WORD, 6'($urandom));
			push_block();
		end
		if ($urandom_range(0, 9) != 0)
			push(CMD_DATA, ZERO_WORD, 6'($urandom));
		for (int j = $urandom_range(0, 3); j > 0; j--)
			push(CMD_QUERY, 16'($urandom), 6'(($urandom_range(0, 4) == 0)
				? $urandom_range(0, 63) : $urandom_range(0, nblk + 1)));
	endtask

	task automatic gen_phase(input int budget, input int big);
		int stop;
		int act;
		int n;
		stop = pushed_cnt + budget;
		for (int j = 0; j < big; j++)
			gen_frame($urandom_range(33, 35));
		while (pushed_cnt < stop) begin
			act = $urandom_range(0, 99);
			if (act < 60) begin
				gen_frame(($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
					: $urandom_range(0, 5));
			end else if (act < 75) begin
				n = ((miss_lim == 0) ? 1 : miss_lim) + 2;
				for (int j = $urandom_range(1, (n > 300) ? 300 : n); j > 0; j--)
					push(CMD_DATA, ($urandom_range(0, 3) == 0) ? ZERO_WORD : nz_word(),
						6'($urandom));
			end else if (act < 88) begin
				for (int j = $urandom_range(1, 6); j > 0; j--)
					push(CMD_QUERY, 16'($urandom), 6'($urandom_range(0, 63)));
			end else begin
				for (int j = $urandom_range(1, 8); j > 0; j--) begin
					case ($urandom_range(0, 4))
						0: push(1'($urandom_range(0, 1)), SYNC_WORD, 6'($urandom));
						1: push(1'($urandom_range(0, 1)), ZERO_WORD, 6'($urandom));
						default: push(1'($urandom_range(0, 1)), 16'($urandom), 6'($urandom));
					endcase
				end
			end
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (accepted_cnt != pushed_cnt || reports_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == {REG_MISS_LIMIT, 2'b00})
			miss_lim = int'(val[7:0]);
		else if (addr == {REG_EMPTY_THR, 2'b00})
			empty_thr = int'(val[7:0]);
	endtask

	task automatic set_limits(input int ml, input int et);
		wait_idle();
		reg_write({REG_MISS_LIMIT, 2'b00}, ml);
		reg_write({REG_EMPTY_THR, 2'b00}, et);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// queries on empty table, misses, leading words, wrapped checksum,
		// extra words, short block at frame end
		push(CMD_QUERY, ZERO_WORD, 6'd0);
		push(CMD_QUERY, 16'hffff, 6'd63);
		push(CMD_DATA, ZERO_WORD, 6'd0);
		push(CMD_DATA, 16'hffff, 6'd63);
		push(CMD_DATA, SYNC_WORD, 6'd0);
		push(CMD_DATA, 16'h0007, 6'd0);
		push(CMD_DATA, SYNC_WORD, 6'd0);
		push(CMD_DATA, 16'h0004, 6'd0);
		push(CMD_DATA, 16'hffff, 6'd0);
		push(CMD_DATA, 16'hffff, 6'd0);
		push(CMD_DATA, 16'h0001, 6'd0);
		push(CMD_DATA, 16'h0002, 6'd0);
		push(CMD_DATA, 16'h0003, 6'd0);
		push(CMD_DATA, SYNC_WORD, 6'd0);
		push(CMD_DATA, 16'h123e, 6'd0);
		push(CMD_DATA, 16'h1234, 6'd0);
		push(CMD_DATA, 16'h0001, 6'd0);
		push(CMD_DATA, 16'h0002, 6'd0);
		push(CMD_DATA, 16'h0003, 6'd0);
		push(CMD_DATA, 16'h0004, 6'd0);
		push(CMD_DATA, 16'hffff, 6'd0);
		push(CMD_DATA, SYNC_WORD, 6'd0);
		push(CMD_DATA, 16'h0101, 6'd0);
		push(CMD_DATA, ZERO_WORD, 6'd0);
		push(CMD_QUERY, ZERO_WORD, 6'd1);
		push(CMD_QUERY, ZERO_WORD, 6'd2);

		wait_idle();
		gen_phase(300, 1);
		set_limits(1, 1);
		gen_phase(300, 0);
		set_limits(255, 255);
		gen_phase(250, 0);
		set_limits(0, 0);
		gen_phase(250, 0);
		set_limits(4, 2);
		gen_phase(300, 1);
		set_limits($urandom_range(1, 20), $urandom_range(1, 8));
		gen_phase(300, 0);

		wait_idle();
		repeat (10) @(negedge clk);
		if (err_cnt == 0 && reports_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
